/* design/sfd_pkg.sv */
// types and constants shared by the slip frame decoder
`default_nettype none
package sfd_pkg;

  localparam logic [7:0]  SlipEnd       = 8'hC0;
  localparam logic [7:0]  SlipEsc       = 8'hDB;
  localparam logic [7:0]  SlipEscEnd    = 8'hDC;
  localparam logic [7:0]  SlipEscEsc    = 8'hDD;
  localparam logic [7:0]  SixEnd        = 8'h70;
  localparam logic [7:0]  SixBase       = 8'h30;
  localparam logic [15:0] StdMinLength  = 16'd2;
  localparam logic [15:0] SixMinLength  = 16'd8;
  localparam logic [15:0] CapacityReset = 16'd1152;
  localparam logic [3:0]  SixBits       = 4'd6;
  localparam logic [3:0]  ByteBits      = 4'd8;

  typedef enum logic {
    CfgSixBitMode   = 1'b0,
    CfgCapacity     = 1'b1
  } cfg_index_e;

  typedef enum logic {
    KindData     = 1'b0,
    KindFrameEnd = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic        escape_pending;
    logic [15:0] byte_count;
    logic [15:0] bit_accumulator;
    logic [3:0]  bits_held;
    logic        frame_overrun;
  } frame_state_t;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   data_byte;
    logic [15:0]  byte_index;
    logic [15:0]  frame_length;
    logic         frame_accepted;
    logic         overrun_seen;
  } result_t;

endpackage
`default_nettype wire

/* design/slip_frame_decoder.sv */
// slip receive deframer: standard escaped and printable six-bit modes
// a byte is held in the input register and its result in the result register before the output shows it
// throughput: one line byte per cycle unless a result waits untaken; the frame state updates in one pass per byte
// the input register and the result register each hold one beat, so input is
// taken while a result waits on the output
// reset: asynchronous active low; frame state cleared, standard mode, capacity 1152
`default_nettype none
module slip_frame_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // line_byte
  input  wire logic        s_axis_tuser,  // line_error
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // data_byte, byte_index, frame_length, frame_accepted, overrun_seen, zero pad
  output logic [47:0]      m_axis_tdata,
  output logic             m_axis_tuser   // result_kind
);

  logic                  six_bit_mode_q;
  logic [15:0]           capacity_q;
  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic                  in_err_q;
  sfd_pkg::frame_state_t state_q;
  sfd_pkg::frame_state_t state_d;
  logic                  dec_valid;
  sfd_pkg::result_t      dec_result;
  logic                  out_valid_q;
  sfd_pkg::result_t      out_result_q;
  logic                  advance;

  sfd_decode u_decode (
    .six_bit_mode_i (six_bit_mode_q),
    .capacity_i     (capacity_q),
    .line_byte_i    (in_byte_q),
    .line_error_i   (in_err_q),
    .state_i        (state_q),
    .state_o        (state_d),
    .result_valid_o (dec_valid),
    .result_o       (dec_result)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready || !dec_valid);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      six_bit_mode_q <= 1'b0;
      capacity_q     <= sfd_pkg::CapacityReset;
    end else if (cfg_we_i) begin
      case (sfd_pkg::cfg_index_e'(cfg_index_i))
        sfd_pkg::CfgSixBitMode: six_bit_mode_q <= cfg_data_i[0];
        sfd_pkg::CfgCapacity:   capacity_q     <= cfg_data_i;
        default:                ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_err_q  <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && dec_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && dec_valid) begin
      out_result_q <= dec_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_result_q.kind;
  assign m_axis_tdata  = {6'd0,
                          out_result_q.overrun_seen,
                          out_result_q.frame_accepted,
                          out_result_q.frame_length,
                          out_result_q.byte_index,
                          out_result_q.data_byte};

`ifndef ASSERT_OFF
  a_bits_held_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.bits_held[0] && state_q.bits_held <= sfd_pkg::SixBits)
    else $error("bits held out of range");

  a_index_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_result_q.kind == sfd_pkg::KindData |->
      out_result_q.byte_index < capacity_q)
    else $error("data beat beyond capacity");

  a_end_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && dec_valid && dec_result.kind == sfd_pkg::KindFrameEnd |=>
      state_q.byte_count == 16'd0 && !state_q.frame_overrun)
    else $error("frame state not cleared at end");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output");
`endif

endmodule
`default_nettype wire

/* design/sfd_decode.sv */
// per-byte slip decode: next frame state and the optional result
`default_nettype none
module sfd_decode (
  input  wire logic                  six_bit_mode_i,
  input  wire logic [15:0]           capacity_i,
  input  wire logic [7:0]            line_byte_i,
  input  wire logic                  line_error_i,
  input  wire sfd_pkg::frame_state_t state_i,
  output sfd_pkg::frame_state_t      state_o,
  output logic                       result_valid_o,
  output sfd_pkg::result_t           result_o
);

  logic        store_req;
  logic [7:0]  store_val;
  logic        end_req;
  logic [15:0] end_min;
  logic [3:0]  held_sum;
  logic [3:0]  held_left;
  logic [15:0] acc_next;
  logic [7:0]  six_val;
  logic [15:0] shifted;

  always_comb begin
    six_val   = line_byte_i - sfd_pkg::SixBase;
    acc_next  = {state_i.bit_accumulator[9:0], six_val[5:0]};
    held_sum  = state_i.bits_held + sfd_pkg::SixBits;
    held_left = held_sum - sfd_pkg::ByteBits;
    shifted   = acc_next >> held_left;
  end

  always_comb begin
    state_o        = state_i;
    store_req      = 1'b0;
    store_val      = line_byte_i;
    end_req        = 1'b0;
    end_min        = sfd_pkg::StdMinLength;
    result_valid_o = 1'b0;
    result_o       = '0;

    if (!line_error_i) begin
      if (six_bit_mode_i) begin
        end_min = sfd_pkg::SixMinLength;
        if (line_byte_i == sfd_pkg::SixEnd) begin
          state_o.bits_held = '0;
          end_req           = 1'b1;
        end else if (line_byte_i >= sfd_pkg::SixBase && line_byte_i < sfd_pkg::SixEnd) begin
          state_o.bit_accumulator = acc_next;
          if (held_sum >= sfd_pkg::ByteBits) begin
            state_o.bits_held = held_left;
            store_req         = 1'b1;
            store_val         = shifted[7:0];
          end else begin
            state_o.bits_held = held_sum;
          end
        end
      end else begin
        unique case (line_byte_i)
          sfd_pkg::SlipEsc: begin
            state_o.escape_pending = 1'b1;
          end
          sfd_pkg::SlipEscEsc: begin
            state_o.escape_pending = 1'b0;
            store_req              = 1'b1;
            store_val = state_i.escape_pending ? sfd_pkg::SlipEsc : line_byte_i;
          end
          sfd_pkg::SlipEscEnd: begin
            state_o.escape_pending = 1'b0;
            store_req              = 1'b1;
            store_val = state_i.escape_pending ? sfd_pkg::SlipEnd : line_byte_i;
          end
          sfd_pkg::SlipEnd: begin
            end_req = 1'b1;
          end
          default: begin
            state_o.escape_pending = 1'b0;
            store_req              = 1'b1;
          end
        endcase
      end
    end

    if (store_req) begin
      if (state_i.byte_count < capacity_i) begin
        result_valid_o      = 1'b1;
        result_o.kind       = sfd_pkg::KindData;
        result_o.data_byte  = store_val;
        result_o.byte_index = state_i.byte_count;
        state_o.byte_count  = state_i.byte_count + 16'd1;
      end else begin
        state_o.frame_overrun = 1'b1;
      end
    end

    if (end_req) begin
      result_valid_o          = 1'b1;
      result_o.kind           = sfd_pkg::KindFrameEnd;
      result_o.frame_length   = state_i.byte_count;
      result_o.frame_accepted = state_i.byte_count > end_min;
      result_o.overrun_seen   = state_i.frame_overrun;
      state_o.byte_count      = '0;
      state_o.escape_pending  = 1'b0;
      state_o.frame_overrun   = 1'b0;
    end
  end

endmodule
`default_nettype wire

/* verif/slip_frame_decoder_tb.sv */
// self-checking testbench for the slip frame decoder, with its own decode model
`timescale 1ns / 100ps
module slip_frame_decoder_tb;
  import sfd_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned LongHold   = 120;
  localparam int unsigned LineItems  = 600;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_error;
  } line_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // line_byte
  logic        s_axis_tuser = 1'b0;  // line_error
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  // data_byte, byte_index, frame_length, frame_accepted, overrun_seen, zero pad
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;  // result_kind

  slip_frame_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // register copies
  logic        six_mode_cfg = 1'b0;
  logic [15:0] capacity_cfg = CapacityReset;

  // frame state copies
  logic        escape_armed = 1'b0;
  logic [15:0] frame_bytes = '0;
  logic [15:0] six_acc = '0;
  logic [3:0]  six_held = '0;
  logic        frame_overrun = 1'b0;

  line_beat_t  line_q[$];
  result_t     decoded_q[$];

  int unsigned mismatch_count = 0;
  int unsigned payload_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  bit          no_idle = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    if (no_idle || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic store_decoded(input logic [7:0] value);
    result_t r;
    r = '0;
    if (frame_bytes < capacity_cfg) begin
      r.kind = KindData;
      r.data_byte = value;
      r.byte_index = frame_bytes;
      decoded_q.push_back(r);
      frame_bytes = frame_bytes + 16'd1;
    end else begin
      frame_overrun = 1'b1;
    end
  endtask

  task automatic close_frame(input logic [15:0] min_length);
    result_t r;
    r = '0;
    r.kind = KindFrameEnd;
    r.frame_length = frame_bytes;
    r.frame_accepted = frame_bytes > min_length;
    r.overrun_seen = frame_overrun;
    decoded_q.push_back(r);
    frame_bytes = '0;
    escape_armed = 1'b0;
    frame_overrun = 1'b0;
  endtask

  task automatic decode_line_byte(input logic [7:0] b, input logic err);
    logic was_escaped;
    if (err) return;
    if (six_mode_cfg) begin
      if (b == SixEnd) begin
        six_held = '0;
        close_frame(SixMinLength);
      end else if (b >= SixBase && b < SixEnd) begin
        six_acc = {six_acc[9:0], 6'(b - SixBase)};
        six_held = six_held + SixBits;
        if (six_held >= ByteBits) begin
          six_held = six_held - ByteBits;
          store_decoded(8'(six_acc >> six_held));
        end
      end
      return;
    end
    was_escaped = escape_armed;
    case (b)
      SlipEsc: begin
        escape_armed = 1'b1;
      end
      SlipEscEsc: begin
        escape_armed = 1'b0;
        store_decoded(was_escaped ? SlipEsc : b);
      end
      SlipEscEnd: begin
        escape_armed = 1'b0;
        store_decoded(was_escaped ? SlipEnd : b);
      end
      SlipEnd: begin
        close_frame(StdMinLength);
      end
      default: begin
        escape_armed = 1'b0;
        store_decoded(b);
      end
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input logic kind, input logic [47:0] beat);
    result_t want;
    if (decoded_q.size() == 0) begin
      $error("result beat with nothing expected: kind %0d, tdata %0h", kind, beat);
      mismatch_count++;
      return;
    end
    want = decoded_q.pop_front();
    compare_field("result_kind", want.kind, kind);
    compare_field("data_byte", want.data_byte, beat[7:0]);
    compare_field("byte_index", want.byte_index, beat[23:8]);
    compare_field("frame_length", want.frame_length, beat[39:24]);
    compare_field("frame_accepted", want.frame_accepted, beat[40]);
    compare_field("overrun_seen", want.overrun_seen, beat[41]);
  endtask

  // line driver
  always @(posedge clk_i) begin : drive_line
    logic       offer;
    line_beat_t nxt;
    if (rst_ni) begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_line_byte(s_axis_tdata, s_axis_tuser);
        offer = 1'b0;
        send_gap = pick_gap();
      end
      if (!offer && line_q.size() != 0) begin
        if (send_gap == 0) begin
          nxt = line_q.pop_front();
          s_axis_tdata <= nxt.line_byte;
          s_axis_tuser <= nxt.line_error;
          offer = 1'b1;
        end else begin
          send_gap--;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // result monitor
  always @(posedge clk_i) begin : watch_results
    logic ready_nxt;
    if (rst_ni) begin
      ready_nxt = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tuser, m_axis_tdata);
        recv_gap = pick_gap();
        ready_nxt = (recv_gap == 0);
      end else if (!m_axis_tready) begin
        if (recv_gap > 1) begin
          recv_gap--;
        end else begin
          recv_gap = 0;
          ready_nxt = 1'b1;
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        recv_gap = LongHold;
        ready_nxt = 1'b0;
      end
      m_axis_tready <= ready_nxt;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_line(input logic [7:0] b, input logic err);
    line_beat_t item;
    item.line_byte = b;
    item.line_error = err;
    line_q.push_back(item);
    if (!err) payload_count++;
  endtask

  // wait until the line side is drained and every result has arrived
  task automatic settle();
    do @(negedge clk_i);
    while (line_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgSixBitMode) six_mode_cfg = value[0];
    else capacity_cfg = value;
  endtask

  task automatic send_std_frame(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) push_line(8'($urandom_range(0, 255)), 1'b1);
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0) b = 8'(SlipEnd + $urandom_range(0, 3) * 0);
      if ($urandom_range(0, 5) == 0) b = 8'(SlipEsc + $urandom_range(0, 2));
      if (b == SlipEnd) begin
        push_line(SlipEsc, 1'b0);
        push_line(SlipEscEnd, 1'b0);
      end else if (b == SlipEsc) begin
        push_line(SlipEsc, 1'b0);
        push_line(SlipEscEsc, 1'b0);
      end else begin
        push_line(b, 1'b0);
      end
    end
    push_line(SlipEnd, 1'b0);
  endtask

  task automatic send_six_frame(input int unsigned n);
    repeat (n) begin
      case ($urandom_range(0, 15))
        0: push_line(8'($urandom_range(0, 255)), 1'b1);
        1: push_line(8'($urandom_range(0, 8'h2F)), 1'b0);
        2: push_line(8'($urandom_range(8'h71, 8'hFF)), 1'b0);
        default: ;
      endcase
      push_line(8'($urandom_range(SixBase, SixEnd - 1)), 1'b0);
    end
    push_line(SixEnd, 1'b0);
  endtask

  initial begin : stimulus
    logic [15:0] cap;
    int unsigned len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // standard mode: field extremes and every escape case
    push_line(8'h00, 1'b0);
    push_line(8'hFF, 1'b0);
    push_line(SlipEsc, 1'b0);
    push_line(SlipEscEnd, 1'b0);
    push_line(SlipEsc, 1'b0);
    push_line(SlipEscEsc, 1'b0);
    push_line(SlipEsc, 1'b0);
    push_line(8'h41, 1'b0);
    push_line(SlipEscEnd, 1'b0);
    push_line(SlipEscEsc, 1'b0);
    push_line(8'h55, 1'b1);
    push_line(SlipEnd, 1'b0);
    push_line(8'h12, 1'b0);
    push_line(SlipEnd, 1'b0);
    push_line(8'h34, 1'b0);
    push_line(8'h56, 1'b0);
    push_line(8'hAB, 1'b0);
    push_line(SlipEnd, 1'b0);
    push_line(SlipEnd, 1'b0);
    settle();

    // six-bit mode: range edges, ignored bytes, partial accumulator kept across modes
    write_reg(CfgSixBitMode, 16'd1);
    push_line(8'h30, 1'b0);
    push_line(8'h6F, 1'b0);
    push_line(8'h2F, 1'b0);
    push_line(8'h71, 1'b0);
    push_line(SlipEnd, 1'b0);
    push_line(8'h40, 1'b1);
    push_line(8'h45, 1'b0);
    push_line(SixEnd, 1'b0);
    push_line(8'h45, 1'b0);
    settle();
    write_reg(CfgSixBitMode, 16'd0);
    push_line(8'h22, 1'b0);
    push_line(SlipEnd, 1'b0);
    settle();
    write_reg(CfgSixBitMode, 16'd1);
    push_line(8'h33, 1'b0);
    push_line(SixEnd, 1'b0);
    settle();

    // zero capacity: every byte overruns
    write_reg(CfgSixBitMode, 16'd0);
    write_reg(CfgCapacity, 16'd0);
    push_line(8'h01, 1'b0);
    push_line(8'h02, 1'b0);
    push_line(SlipEnd, 1'b0);
    settle();

    // receiver holds off while the line side keeps offering
    write_reg(CfgCapacity, 16'hFFFF);
    no_idle = 1'b1;
    hold_req++;
    repeat (40) push_line(8'($urandom_range(0, 8'hBF)), 1'b0);
    push_line(SlipEnd, 1'b0);
    settle();
    no_idle = 1'b0;

    while (payload_count < LineItems) begin
      settle();
      case ($urandom_range(0, 5))
        0: cap = 16'd0;
        1, 2: cap = 16'($urandom_range(1, 6));
        3: cap = CapacityReset;
        4: cap = 16'hFFFF;
        default: cap = 16'($urandom_range(0, 16'hFFFF));
      endcase
      if ($urandom_range(0, 2) != 0) write_reg(CfgSixBitMode, 16'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0) write_reg(CfgCapacity, cap);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 12);
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4))
            push_line(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (six_mode_cfg) begin
          send_six_frame(len + $urandom_range(0, 8));
        end else begin
          send_std_frame(len);
        end
      end
    end

    do @(negedge clk_i);
    while (line_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0);
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/sfd_pkg.sv
design/sfd_decode.sv
design/slip_frame_decoder.sv
verif/slip_frame_decoder_tb.sv
